// ===== design/binary_lifting_lca_top_defines.svh =====
// Assertion macros for the binary lifting LCA block.
// Used by binary_lifting_lca_top; expects signals named clock and reset in scope.
`ifndef BINARY_LIFTING_LCA_TOP_DEFINES_SVH
`define BINARY_LIFTING_LCA_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/blca_pkg.sv =====
// Package for the binary lifting LCA block: control word types and the microprogram.
// No dependencies; used by binary_lifting_lca_top.
package blca_pkg;

   typedef logic [4:0] pc_type;

   // request kinds carried in req_tuser[0]
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic [9:0] DEPTH_MAX = 10'h3FF;

   // microprogram step addresses
   localparam pc_type PC_IDLE  = 5'd0;
   localparam pc_type PC_I0    = 5'd1;
   localparam pc_type PC_I1    = 5'd2;
   localparam pc_type PC_I2    = 5'd3;
   localparam pc_type PC_I3    = 5'd4;
   localparam pc_type PC_Q0    = 5'd5;
   localparam pc_type PC_Q1    = 5'd6;
   localparam pc_type PC_Q2    = 5'd7;
   localparam pc_type PC_Q3    = 5'd8;
   localparam pc_type PC_Q4    = 5'd9;
   localparam pc_type PC_Q5    = 5'd10;
   localparam pc_type PC_Q6    = 5'd11;
   localparam pc_type PC_Q7    = 5'd12;
   localparam pc_type PC_Q8    = 5'd13;
   localparam pc_type PC_Q9    = 5'd14;
   localparam pc_type PC_EMIT  = 5'd15;
   localparam pc_type PC_FAIL  = 5'd16;

   // memory read selection
   typedef enum logic [2:0] {
      RD_NONE,
      RD_DEPTH_Y,
      RD_DEPTH_XY,
      RD_DEPTH_TA,
      RD_LIFT_CUR,
      RD_LIFT_Y,
      RD_LIFT_XY,
      RD_LIFT_X0
   } rd_type;

   // datapath operation
   typedef enum logic [3:0] {
      EX_NONE,
      EX_ACCEPT,
      EX_INS_CHECK,
      EX_INS_BASE,
      EX_INS_LEVEL,
      EX_Q_CHECK,
      EX_ORDER,
      EX_LIFT1,
      EX_MEET,
      EX_LIFT2,
      EX_TOP,
      EX_FAIL,
      EX_EMIT
   } ex_type;

   // sequencing
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_GOTO,
      BR_COND,
      BR_DISPATCH,
      BR_UP_END,
      BR_DOWN,
      BR_END
   } br_type;

   typedef struct packed {
      rd_type rd;
      ex_type ex;
      br_type br;
      pc_type tgt;
   } ctrl_type;

   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type w;
      case (pc)
         PC_IDLE: w = '{RD_NONE,     EX_ACCEPT,    BR_DISPATCH, PC_IDLE};
         PC_I0:   w = '{RD_DEPTH_Y,  EX_INS_CHECK, BR_COND,     PC_IDLE};
         PC_I1:   w = '{RD_NONE,     EX_INS_BASE,  BR_COND,     PC_IDLE};
         PC_I2:   w = '{RD_LIFT_CUR, EX_NONE,      BR_NEXT,     PC_IDLE};
         PC_I3:   w = '{RD_NONE,     EX_INS_LEVEL, BR_UP_END,   PC_I2};
         PC_Q0:   w = '{RD_DEPTH_XY, EX_Q_CHECK,   BR_COND,     PC_FAIL};
         PC_Q1:   w = '{RD_NONE,     EX_ORDER,     BR_NEXT,     PC_IDLE};
         PC_Q2:   w = '{RD_LIFT_Y,   EX_NONE,      BR_NEXT,     PC_IDLE};
         PC_Q3:   w = '{RD_DEPTH_TA, EX_NONE,      BR_NEXT,     PC_IDLE};
         PC_Q4:   w = '{RD_NONE,     EX_LIFT1,     BR_DOWN,     PC_Q2};
         PC_Q5:   w = '{RD_NONE,     EX_MEET,      BR_COND,     PC_EMIT};
         PC_Q6:   w = '{RD_LIFT_XY,  EX_NONE,      BR_NEXT,     PC_IDLE};
         PC_Q7:   w = '{RD_NONE,     EX_LIFT2,     BR_DOWN,     PC_Q6};
         PC_Q8:   w = '{RD_LIFT_X0,  EX_NONE,      BR_NEXT,     PC_IDLE};
         PC_Q9:   w = '{RD_NONE,     EX_TOP,       BR_NEXT,     PC_IDLE};
         PC_EMIT: w = '{RD_NONE,     EX_EMIT,      BR_END,      PC_IDLE};
         PC_FAIL: w = '{RD_NONE,     EX_FAIL,      BR_GOTO,     PC_EMIT};
         default: w = '{RD_NONE,     EX_NONE,      BR_GOTO,     PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== design/binary_lifting_lca_top.sv =====
// Binary lifting LCA block: keeps 2^i ancestors and depths of tree nodes, answers LCA
// queries. Depends on blca_pkg and binary_lifting_lca_top_defines.svh.
//
// Usage:
//   req channel (req_tvalid/req_tready): one transaction is an insert (node_a under
//   parent node_b, or a root when has_parent is 0) or a query (LCA of node_a, node_b).
//   rsp channel: one transaction per query, none per insert; found = 0 means the
//   nodes share no ancestor or one is out of range, with ancestor forced to zero.
//   A microprogram in blca_pkg steps a small datapath over two memories (lift table
//   and depth), each with two registered read ports and one write port.
//   An insert holds the block for one read and one write of the lift table per level.
//   A query steps down the levels for the one-sided lift (table read, depth read,
//   compare), then again for the joint lift (table reads, lift step); it ends early
//   when one node is the other's ancestor. One item is in flight at a time.
//   The result sits in an output register; the next item is accepted while it waits.
//   A second result only stalls the sequencer while the receiver holds rsp_tready low.
//   Reset returns the sequencer to idle and drops any pending result; both memories
//   are undefined until written, so nodes must be inserted after their parents.
`include "binary_lifting_lca_top_defines.svh"

module binary_lifting_lca_top #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] node_a, [19:10] node_b, [23:20] zero
   input  logic [1:0]  req_tuser,   // [0] req_type, [1] has_parent
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] ancestor, [15:10] zero
   output logic        rsp_tuser    // [0] found
);

   // node fields are 10 bits wide, so at most 1024 nodes ever reach the memories
   localparam int NODE_CNT   = (NODES > 1024) ? 1024 : NODES;
   localparam int NIDX_W     = $clog2(NODE_CNT);
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ADDR_W     = NIDX_W + LVL_W;
   localparam int LIFT_DEPTH = NODE_CNT * (2 ** LVL_W);
   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

   // ---------------------------------------------------------------------------------
   // Storage: lift table addressed {node, level}, depth table addressed by node
   // ---------------------------------------------------------------------------------
   logic [10:0] lift_mem  [LIFT_DEPTH];
   logic [9:0]  depth_mem [NODE_CNT];

   // sequencer and datapath registers
   blca_pkg::pc_type   pc_ff, pc_in;
   blca_pkg::ctrl_type ctrl;
   logic [9:0]       x_ff, x_in, y_ff, y_in, dx_ff, dx_in;
   logic             hp_ff, hp_in;
   logic [10:0]      cur_ff, cur_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [9:0]       res_node_ff, res_node_in;
   logic             res_found_ff, res_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [9:0]       rsp_node_ff;
   logic             rsp_found_ff;

   // registered memory read data
   logic [10:0] ta_ff, tb_ff;
   logic [9:0]  da_ff, db_ff;

   // memory control
   logic              lift_rea, lift_reb, lift_we;
   logic [ADDR_W-1:0] lift_raddr_a, lift_raddr_b, lift_waddr;
   logic [10:0]       lift_wdata;
   logic              depth_rea, depth_reb, depth_we;
   logic [NIDX_W-1:0] depth_raddr_a, depth_raddr_b;
   logic [9:0]        depth_wdata;

   logic        take;
   logic        stall;
   logic        rsp_load;
   logic [10:0] entry;

   function automatic logic node_ok(input logic [9:0] n);
      return 32'(n) < 32'(NODES);
   endfunction

   assign req_tready = (pc_ff == blca_pkg::PC_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_node_ff};
   assign rsp_tuser  = rsp_found_ff;

   // ---------------------------------------------------------------------------------
   // Memories: one write port, two registered read ports each
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (lift_we) begin
         lift_mem[lift_waddr] <= lift_wdata;
      end
      if (lift_rea) begin
         ta_ff <= lift_mem[lift_raddr_a];
      end
      if (lift_reb) begin
         tb_ff <= lift_mem[lift_raddr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[x_ff[NIDX_W-1:0]] <= depth_wdata;
      end
      if (depth_rea) begin
         da_ff <= depth_mem[depth_raddr_a];
      end
      if (depth_reb) begin
         db_ff <= depth_mem[depth_raddr_b];
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= blca_pkg::PC_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      dx_ff        <= dx_in;
      hp_ff        <= hp_in;
      cur_ff       <= cur_in;
      res_node_ff  <= res_node_in;
      res_found_ff <= res_found_in;
      if (rsp_load) begin
         rsp_node_ff  <= res_node_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Control word decode: read port selection
   // ---------------------------------------------------------------------------------
   always_comb begin
      ctrl          = blca_pkg::ucode(pc_ff);
      lift_rea      = 1'b0;
      lift_reb      = 1'b0;
      depth_rea     = 1'b0;
      depth_reb     = 1'b0;
      lift_raddr_a  = {x_ff[NIDX_W-1:0], lvl_ff};
      lift_raddr_b  = {y_ff[NIDX_W-1:0], lvl_ff};
      depth_raddr_a = x_ff[NIDX_W-1:0];
      depth_raddr_b = y_ff[NIDX_W-1:0];
      case (ctrl.rd)
         blca_pkg::RD_NONE: begin
         end
         blca_pkg::RD_DEPTH_Y: begin
            depth_rea     = 1'b1;
            depth_raddr_a = y_ff[NIDX_W-1:0];
         end
         blca_pkg::RD_DEPTH_XY: begin
            depth_rea = 1'b1;
            depth_reb = 1'b1;
         end
         blca_pkg::RD_DEPTH_TA: begin
            // depth of the ancestor just read from the lift table
            depth_rea     = 1'b1;
            depth_raddr_a = ta_ff[NIDX_W-1:0];
         end
         blca_pkg::RD_LIFT_CUR: begin
            // level i of a new node comes from level i-1 of its 2^(i-1) ancestor
            lift_rea     = 1'b1;
            lift_raddr_a = {cur_ff[NIDX_W-1:0], lvl_ff - LVL_W'(1)};
         end
         blca_pkg::RD_LIFT_Y: begin
            lift_rea     = 1'b1;
            lift_raddr_a = {y_ff[NIDX_W-1:0], lvl_ff};
         end
         blca_pkg::RD_LIFT_XY: begin
            lift_rea = 1'b1;
            lift_reb = 1'b1;
         end
         blca_pkg::RD_LIFT_X0: begin
            lift_rea     = 1'b1;
            lift_raddr_a = {x_ff[NIDX_W-1:0], {LVL_W{1'b0}}};
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Datapath operation and next step
   // ---------------------------------------------------------------------------------
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      dx_in        = dx_ff;
      hp_in        = hp_ff;
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      res_node_in  = res_node_ff;
      res_found_in = res_found_ff;
      take         = 1'b0;
      stall        = 1'b0;
      rsp_load     = 1'b0;
      lift_we      = 1'b0;
      lift_waddr   = {x_ff[NIDX_W-1:0], lvl_ff};
      lift_wdata   = cur_ff;
      depth_we     = 1'b0;
      depth_wdata  = 10'd0;
      entry        = 11'd0;

      case (ctrl.ex)
         blca_pkg::EX_NONE: begin
         end
         blca_pkg::EX_ACCEPT: begin
            // capture the payload; it only matters on the accepting edge
            take   = req_tvalid;
            x_in   = req_tdata[9:0];
            y_in   = req_tdata[19:10];
            hp_in  = req_tuser[1];
            lvl_in = '0;
         end
         blca_pkg::EX_INS_CHECK: begin
            // drop an insert that names a node beyond the table
            take = !(node_ok(x_ff) && (!hp_ff || node_ok(y_ff)));
         end
         blca_pkg::EX_INS_BASE: begin
            entry       = hp_ff ? {1'b1, y_ff} : 11'd0;
            depth_we    = 1'b1;
            depth_wdata = !hp_ff ? 10'd0 :
                          (da_ff == blca_pkg::DEPTH_MAX) ? blca_pkg::DEPTH_MAX :
                          da_ff + 10'd1;
            lift_we     = 1'b1;
            lift_wdata  = entry;
            cur_in      = entry;
            lvl_in      = LVL_W'(LEVELS > 1);
            take        = (LEVELS == 1);
         end
         blca_pkg::EX_INS_LEVEL: begin
            // a missing ancestor stays missing at every higher level
            entry      = cur_ff[10] ? ta_ff : 11'd0;
            lift_we    = 1'b1;
            lift_wdata = entry;
            cur_in     = entry;
         end
         blca_pkg::EX_Q_CHECK: begin
            take = !(node_ok(x_ff) && node_ok(y_ff));
         end
         blca_pkg::EX_ORDER: begin
            // keep the deeper node in y
            if (da_ff > db_ff) begin
               x_in  = y_ff;
               y_in  = x_ff;
               dx_in = db_ff;
            end else begin
               dx_in = da_ff;
            end
            lvl_in = LAST_LVL;
         end
         blca_pkg::EX_LIFT1: begin
            if (ta_ff[10] && (da_ff >= dx_ff)) begin
               y_in = ta_ff[9:0];
            end
         end
         blca_pkg::EX_MEET: begin
            take         = (x_ff == y_ff);
            res_node_in  = x_ff;
            res_found_in = 1'b1;
            lvl_in       = LAST_LVL;
         end
         blca_pkg::EX_LIFT2: begin
            if (ta_ff[10] && tb_ff[10] && (ta_ff != tb_ff)) begin
               x_in = ta_ff[9:0];
               y_in = tb_ff[9:0];
            end
         end
         blca_pkg::EX_TOP: begin
            res_node_in  = ta_ff[10] ? ta_ff[9:0] : 10'd0;
            res_found_in = ta_ff[10];
         end
         blca_pkg::EX_FAIL: begin
            res_node_in  = 10'd0;
            res_found_in = 1'b0;
         end
         blca_pkg::EX_EMIT: begin
            // hold while the previous result is still waiting
            stall    = rsp_valid_ff && !rsp_tready;
            rsp_load = !stall;
         end
         default: begin
         end
      endcase

      case (ctrl.br)
         blca_pkg::BR_NEXT: begin
            pc_in = pc_ff + 5'd1;
         end
         blca_pkg::BR_GOTO: begin
            pc_in = ctrl.tgt;
         end
         blca_pkg::BR_COND: begin
            pc_in = take ? ctrl.tgt : pc_ff + 5'd1;
         end
         blca_pkg::BR_DISPATCH: begin
            if (!take) begin
               pc_in = pc_ff;
            end else if (req_tuser[0] == blca_pkg::REQ_QUERY) begin
               pc_in = blca_pkg::PC_Q0;
            end else begin
               pc_in = blca_pkg::PC_I0;
            end
         end
         blca_pkg::BR_UP_END: begin
            if (lvl_ff == LAST_LVL) begin
               pc_in = blca_pkg::PC_IDLE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
               pc_in  = ctrl.tgt;
            end
         end
         blca_pkg::BR_DOWN: begin
            if (lvl_ff == '0) begin
               pc_in = pc_ff + 5'd1;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
               pc_in  = ctrl.tgt;
            end
         end
         blca_pkg::BR_END: begin
            pc_in = stall ? pc_ff : blca_pkg::PC_IDLE;
         end
         default: begin
            pc_in = blca_pkg::PC_IDLE;
         end
      endcase

      // advance the output register: load a new result or drain a taken one
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   `BLCA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, pc_ff != blca_pkg::PC_IDLE, "sequencer idle right after an accepted transaction")
   `BLCA_ASSERT_NOW(a_no_overwrite, rsp_load, !rsp_valid_ff || rsp_tready, "pending result overwritten")
   `BLCA_ASSERT_NOW(a_level_range, 1'b1, lvl_ff <= LAST_LVL, "level counter out of range")
   `BLCA_ASSERT_NOW(a_empty_is_zero, rsp_valid_ff && !rsp_found_ff, rsp_node_ff == 10'd0, "ancestor not zero when none found")

endmodule

// ===== test/tb_binary_lifting_lca_top.sv =====
// Testbench for binary_lifting_lca_top: drives insert and query transactions on the
// req stream and checks every LCA answer on the rsp stream against a scoreboard.
// Depends on blca_pkg and the binary_lifting_lca_top RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_binary_lifting_lca_top;

   localparam int NODE_COUNT  = 1024;
   localparam int LEVEL_COUNT = 10;
   // worst query occupancy of the sequencer, used for the drain pause at the end
   localparam int QUERY_CYCLES = 5 * LEVEL_COUNT + 7;

   typedef struct packed {
      logic [9:0] ancestor;
      logic       found;
   } lca_answer_type;

   // Scoreboard: mirrors the lift table and the depths, predicts each LCA answer
   // when a query is accepted, and checks answers in order as they come out.
   class lca_scoreboard_type;
      bit [10:0]      lift_mem [NODE_COUNT * LEVEL_COUNT];
      bit [9:0]       depth_mem [NODE_COUNT];
      lca_answer_type expected_answers [$];
      int unsigned    error_count;

      function new();
         error_count = 0;
      endfunction

      function int slot_of(bit [9:0] node, int level);
         return int'(node) * LEVEL_COUNT + level;
      endfunction

      function void insert_node(bit [9:0] a, bit [9:0] b, bit has_par);
         bit [10:0] prev;
         if (a >= NODE_COUNT || (has_par && b >= NODE_COUNT))
            return;
         // read the parent's depth first: a node may be its own parent
         if (has_par) begin
            depth_mem[a] = (depth_mem[b] >= blca_pkg::DEPTH_MAX) ? blca_pkg::DEPTH_MAX :
                           depth_mem[b] + 10'd1;
            lift_mem[slot_of(a, 0)] = {1'b1, b};
         end else begin
            depth_mem[a] = '0;
            lift_mem[slot_of(a, 0)] = '0;
         end
         for (int i = 1; i < LEVEL_COUNT; i++) begin
            prev = lift_mem[slot_of(a, i - 1)];
            lift_mem[slot_of(a, i)] = prev[10] ? lift_mem[slot_of(prev[9:0], i - 1)] : '0;
         end
      endfunction

      function lca_answer_type query_lca(bit [9:0] x, bit [9:0] y);
         lca_answer_type answer;
         bit [9:0]       t;
         bit [10:0]      ex;
         bit [10:0]      ey;
         answer = '{ancestor: '0, found: 1'b0};
         if (x >= NODE_COUNT || y >= NODE_COUNT)
            return answer;
         // keep y the deeper node
         if (depth_mem[x] > depth_mem[y]) begin
            t = x;
            x = y;
            y = t;
         end
         for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            ey = lift_mem[slot_of(y, i)];
            if (ey[10] && depth_mem[ey[9:0]] >= depth_mem[x])
               y = ey[9:0];
         end
         if (x == y) begin
            answer = '{ancestor: x, found: 1'b1};
            return answer;
         end
         // joint lift: take a level only when both ancestors exist and differ
         for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            ex = lift_mem[slot_of(x, i)];
            ey = lift_mem[slot_of(y, i)];
            if (ex[10] && ey[10] && ex != ey) begin
               x = ex[9:0];
               y = ey[9:0];
            end
         end
         ex = lift_mem[slot_of(x, 0)];
         if (ex[10])
            answer = '{ancestor: ex[9:0], found: 1'b1};
         return answer;
      endfunction

      function void note_request(logic kind, bit [9:0] a, bit [9:0] b, bit has_par);
         if (kind == blca_pkg::REQ_INSERT)
            insert_node(a, b, has_par);
         else
            expected_answers.insert(expected_answers.size(), query_lca(a, b));
      endfunction

      function void check_response(logic [9:0] ancestor, logic found);
         lca_answer_type want;
         if (expected_answers.size() == 0) begin
            $error("unexpected result: ancestor %0d found %0b", ancestor, found);
            error_count++;
            return;
         end
         want = expected_answers.pop_front();
         if (found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, found);
            error_count++;
         end
         if (ancestor !== want.ancestor) begin
            $error("ancestor mismatch: expected %0d, actual %0d", want.ancestor, ancestor);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      function void report_leftover();
         if (expected_answers.size() != 0) begin
            $error("%0d expected results never arrived", expected_answers.size());
            error_count++;
         end
      endfunction
   endclass

   // DUT ports; every input starts at a known value
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [9:0] node_a, [19:10] node_b, [23:20] zero
   logic [1:0]  req_tuser  = '0;   // [0] req_type, [1] has_parent
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [9:0] ancestor, [15:10] zero
   logic        rsp_tuser;         // [0] found

   // idling controls, changed per phase by the main sequence
   int unsigned tx_idle_pct  = 0;
   int unsigned rx_stall_pct = 0;
   // long receiver hold: requested by the main sequence, timed by its own process
   bit          pressure_req = 1'b0;
   bit          rx_hold      = 1'b0;

   // nodes already inserted; only these may be read by a later transaction
   bit       node_written [NODE_COUNT];
   bit [9:0] written_nodes [$];

   lca_scoreboard_type sb = new();

   binary_lifting_lca_top #(
      .NODES (NODE_COUNT),
      .LEVELS(LEVEL_COUNT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("tb_binary_lifting_lca_top NOT OK");
      $finish;
   end

   // Pressure: once requested, hold the receiver off for a long stretch, then release it.
   initial begin
      wait (pressure_req);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // Receiver: check each accepted result, then pick the next rsp_tready.
   // A pressure hold keeps rsp_tready low for a long stretch so the block fills up.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_response(rsp_tdata[9:0], rsp_tuser);
      if (rx_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Offer one transaction and return at the edge where it is accepted, with tvalid
   // still high so the next call can follow back to back. Called at a clock edge.
   task automatic push_item(logic kind, bit [9:0] a, bit [9:0] b, bit has_par);
      int unsigned gap;
      if ($urandom_range(99) < tx_idle_pct) begin
         // mostly short gaps, sometimes long enough to span a whole query
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, b, a};
      req_tuser  <= {has_par, kind};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, a, b, has_par);
      // track inserted nodes in issue order; acceptance keeps the same order
      if (kind == blca_pkg::REQ_INSERT && !node_written[a]) begin
         node_written[a] = 1'b1;
         written_nodes.insert(written_nodes.size(), a);
      end
   endtask

   function automatic bit [9:0] pick_written();
      return written_nodes[$urandom_range(written_nodes.size() - 1)];
   endfunction

   // Directed start: field extremes, roots, separate trees, a node that is the other's
   // ancestor, a query of a node with itself, a re-insert that leaves an inconsistent
   // table below it, and a node made its own parent.
   task automatic run_directed();
      push_item(blca_pkg::REQ_INSERT, 10'd0,    10'd1023, 1'b0);
      push_item(blca_pkg::REQ_INSERT, 10'd1023, 10'd0,    1'b1);
      push_item(blca_pkg::REQ_INSERT, 10'd512,  10'd1023, 1'b1);
      push_item(blca_pkg::REQ_INSERT, 10'd341,  10'd1023, 1'b1);
      push_item(blca_pkg::REQ_INSERT, 10'd682,  10'd512,  1'b1);
      push_item(blca_pkg::REQ_INSERT, 10'd1,    10'd0,    1'b0);
      push_item(blca_pkg::REQ_INSERT, 10'd2,    10'd1,    1'b1);
      push_item(blca_pkg::REQ_QUERY,  10'd0,    10'd0,    1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd682,  10'd341,  1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd341,  10'd682,  1'b1);
      push_item(blca_pkg::REQ_QUERY,  10'd682,  10'd0,    1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd0,    10'd682,  1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd2,    10'd682,  1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd1,    10'd1,    1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd1023, 10'd2,    1'b0);
      push_item(blca_pkg::REQ_INSERT, 10'd512,  10'd2,    1'b1);
      push_item(blca_pkg::REQ_QUERY,  10'd682,  10'd2,    1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd512,  10'd341,  1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd682,  10'd1023, 1'b0);
      push_item(blca_pkg::REQ_INSERT, 10'd1,    10'd1,    1'b1);
      push_item(blca_pkg::REQ_QUERY,  10'd2,    10'd1,    1'b0);
      push_item(blca_pkg::REQ_QUERY,  10'd1023, 10'd1023, 1'b0);
   endtask

   // Random trees: inserts with a parent always name an already inserted one, queries only
   // inserted nodes. Parents lean toward recent nodes so that the trees grow deep.
   task automatic run_random(int count, int unsigned query_pct);
      bit [9:0] a;
      bit [9:0] b;
      bit       has_par;
      int       lo;
      for (int n = 0; n < count; n++) begin
         if (written_nodes.size() != 0 && $urandom_range(99) < query_pct) begin
            a = pick_written();
            b = ($urandom_range(9) == 0) ? a : pick_written();
            push_item(blca_pkg::REQ_QUERY, a, b, 1'($urandom_range(1)));
         end else begin
            if (written_nodes.size() == 0 ||
                (written_nodes.size() < NODE_COUNT && $urandom_range(99) < 75)) begin
               do a = 10'($urandom_range(NODE_COUNT - 1)); while (node_written[a]);
            end else begin
               a = pick_written();
            end
            if (written_nodes.size() == 0 || $urandom_range(99) < 10) begin
               has_par = 1'b0;
               b       = 10'($urandom_range(NODE_COUNT - 1));
            end else begin
               has_par = 1'b1;
               lo = ($urandom_range(1) == 1 && written_nodes.size() > 6) ?
                    written_nodes.size() - 6 : 0;
               b = written_nodes[$urandom_range(lo, written_nodes.size() - 1)];
            end
            push_item(blca_pkg::REQ_INSERT, a, b, has_par);
         end
      end
   endtask

   // One chain through every node in random order reaches the deepest lifting level;
   // hanging its root under its tail then drives the depth into saturation.
   task automatic run_deep_chain();
      bit [9:0] chain_order [NODE_COUNT];
      bit [9:0] t;
      int       j;
      for (int i = 0; i < NODE_COUNT; i++)
         chain_order[i] = 10'(i);
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = chain_order[i];
         chain_order[i] = chain_order[j];
         chain_order[j] = t;
      end
      push_item(blca_pkg::REQ_INSERT, chain_order[0],
                10'($urandom_range(NODE_COUNT - 1)), 1'b0);
      for (int i = 1; i < NODE_COUNT; i++) begin
         push_item(blca_pkg::REQ_INSERT, chain_order[i], chain_order[i - 1], 1'b1);
         if ($urandom_range(99) < 4)
            push_item(blca_pkg::REQ_QUERY, chain_order[$urandom_range(i)],
                      chain_order[$urandom_range(i)], 1'b0);
      end
      push_item(blca_pkg::REQ_INSERT, chain_order[0], chain_order[NODE_COUNT - 1], 1'b1);
      for (int i = 1; i < 5; i++)
         push_item(blca_pkg::REQ_INSERT, chain_order[i], chain_order[i - 1], 1'b1);
      // probe the saturated region and long lifts across the chain
      for (int n = 0; n < 40; n++) begin
         push_item(blca_pkg::REQ_QUERY, chain_order[$urandom_range(NODE_COUNT - 1)],
                   chain_order[$urandom_range(n % 2 == 0 ? 0 : 900, NODE_COUNT - 1)],
                   1'b0);
      end
   endtask

   // Main sequence.
   initial begin
      int drain_cycles;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // no idling
      tx_idle_pct = 0;   rx_stall_pct = 0;
      run_random(150, 55);
      // sender idles
      tx_idle_pct = 67;  rx_stall_pct = 0;
      run_random(150, 55);
      // receiver stalls
      tx_idle_pct = 0;   rx_stall_pct = 67;
      run_random(150, 55);
      // both idle now and then
      tx_idle_pct = 19;  rx_stall_pct = 19;
      run_random(150, 55);

      // hold off the receiver while queries keep coming so req_tready drops
      tx_idle_pct = 0;   rx_stall_pct = 0;
      pressure_req <= 1'b1;
      run_random(30, 90);

      tx_idle_pct = 19;  rx_stall_pct = 19;
      run_deep_chain();
      req_tvalid <= 1'b0;

      // drain: wait for every outstanding answer, then let the block settle
      drain_cycles = 0;
      while (sb.pending() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      sb.report_leftover();
      repeat (2 * QUERY_CYCLES) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("tb_binary_lifting_lca_top OK");
      end else begin
         $display("tb_binary_lifting_lca_top NOT OK");
      end
      $finish;
   end

endmodule
